// File: rtl/rc_frame_check_failsafe_top_defines.svh
// Assertion macros used by the checker file.
`ifndef RC_FRAME_CHECK_FAILSAFE_TOP_DEFINES_SVH
`define RC_FRAME_CHECK_FAILSAFE_TOP_DEFINES_SVH

// Check a property on the block clock, ignored while reset is held.
`define RCFC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on the block clock, also across reset.
`define RCFC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: rtl/rcfc_pkg.sv
package rcfc_pkg;

    localparam int unsigned CFG_ADDR_WIDTH = 4;
    localparam int unsigned CFG_DATA_WIDTH = 32;

    localparam logic [1:0] REG_HEADER_VALUE     = 2'd0;
    localparam logic [1:0] REG_DISCONNECT_LIMIT = 2'd1;
    localparam logic [1:0] REG_ARM_X_MAX        = 2'd2;
    localparam logic [1:0] REG_ARM_Y_MIN        = 2'd3;

    localparam logic [7:0] HEADER_VALUE_RST     = 8'd84;
    localparam logic [7:0] DISCONNECT_LIMIT_RST = 8'd10;
    localparam logic [7:0] ARM_X_MAX_RST        = 8'd50;
    localparam logic [7:0] ARM_Y_MIN_RST        = 8'd230;

    localparam logic [7:0] MASK_LX = 8'b1100_0000;
    localparam logic [7:0] MASK_LY = 8'b0011_0000;
    localparam logic [7:0] MASK_RX = 8'b0000_1100;
    localparam logic [7:0] MASK_RY = 8'b0000_0011;

    localparam logic [7:0] IDLE_MAX     = 8'hFF;
    localparam logic [1:0] SW_RELEASED  = 2'b11;
    localparam int unsigned LEFT_SW_BIT  = 0;
    localparam int unsigned RIGHT_SW_BIT = 1;

    typedef struct packed {
        logic [7:0] header_value;
        logic [7:0] disconnect_limit;
        logic [7:0] arm_x_max;
        logic [7:0] arm_y_min;
    } cfg_t;

    typedef struct packed {
        logic       frame_present;
        logic [7:0] header_byte;
        logic [7:0] left_stick_x;
        logic [7:0] left_stick_y;
        logic [7:0] right_stick_x;
        logic [7:0] right_stick_y;
        logic [7:0] switch_byte;
        logic [7:0] check_byte;
    } in_item_t;

    typedef struct packed {
        logic       armed;
        logic       stop_motors;
        logic [7:0] thrust;
        logic [7:0] yaw;
        logic [7:0] pitch;
        logic [7:0] roll;
        logic       left_press;
        logic       right_press;
        logic       header_fault;
        logic       checksum_fault;
        logic       link_lost;
    } out_item_t;

    function automatic logic [7:0] pair_sum(input logic [7:0] lx, input logic [7:0] ly,
                                            input logic [7:0] rx, input logic [7:0] ry);
        return (lx & MASK_LX) | (ly & MASK_LY) | (rx & MASK_RX) | (ry & MASK_RY);
    endfunction

endpackage

// File: rtl/rcfc_core.sv
module rcfc_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  rcfc_pkg::cfg_t     cfg,
    input  rcfc_pkg::in_item_t item,
    output rcfc_pkg::out_item_t result
);

    logic [7:0] stick_reg [4];
    logic [7:0] stick_next [4];
    // Last stored switch bits; they double as the previous-switch state of the edge detector.
    logic [1:0] switch_reg;
    logic [1:0] switch_next;
    logic [7:0] idle_reg;
    logic [7:0] idle_next;
    logic       header_bad_reg;
    logic       header_bad_next;
    logic       check_bad_reg;
    logic       check_bad_next;
    logic       arm_reg;
    logic       arm_next;

    logic       header_ok;
    logic       sum_ok;
    logic       arm_req;
    logic       lpress;
    logic       rpress;
    logic       lost;
    logic       stop;

    always_comb begin
        header_ok = (item.header_byte == cfg.header_value);
        sum_ok    = (item.check_byte == rcfc_pkg::pair_sum(item.left_stick_x, item.left_stick_y,
                                                            item.right_stick_x,
                                                            item.right_stick_y));
        if (item.frame_present) begin
            stick_next[0]   = item.left_stick_x;
            stick_next[1]   = item.left_stick_y;
            stick_next[2]   = item.right_stick_x;
            stick_next[3]   = item.right_stick_y;
            switch_next     = item.switch_byte[1:0];
            idle_next       = 8'd0;
            header_bad_next = header_bad_reg | ~header_ok;
            check_bad_next  = check_bad_reg | (header_ok & ~sum_ok);
        end else begin
            stick_next      = stick_reg;
            switch_next     = switch_reg;
            // saturate at the top of the range
            idle_next       = (idle_reg == rcfc_pkg::IDLE_MAX) ? idle_reg : idle_reg + 8'd1;
            header_bad_next = header_bad_reg;
            check_bad_next  = check_bad_reg;
        end

        arm_req = (stick_next[0] <= cfg.arm_x_max) && (stick_next[1] >= cfg.arm_y_min);
        lpress  = ~switch_next[rcfc_pkg::LEFT_SW_BIT] & switch_reg[rcfc_pkg::LEFT_SW_BIT];
        rpress  = ~switch_next[rcfc_pkg::RIGHT_SW_BIT] & switch_reg[rcfc_pkg::RIGHT_SW_BIT];
        lost    = (idle_next > cfg.disconnect_limit);
        stop    = lpress | lost | header_bad_next | check_bad_next;
        // stop overrides an arm request of the same poll
        arm_next = (arm_reg | arm_req) & ~stop;

        result.armed          = arm_next;
        result.stop_motors    = stop;
        result.thrust         = stick_next[0];
        result.yaw            = stick_next[1];
        result.pitch          = stick_next[2];
        result.roll           = stick_next[3];
        result.left_press     = lpress;
        result.right_press    = rpress;
        result.header_fault   = header_bad_next;
        result.checksum_fault = check_bad_next;
        result.link_lost      = lost;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stick_reg      <= '{default: 8'd0};
            switch_reg     <= rcfc_pkg::SW_RELEASED;
            idle_reg       <= 8'd0;
            header_bad_reg <= 1'b0;
            check_bad_reg  <= 1'b0;
            arm_reg        <= 1'b0;
        end else if (advance) begin
            stick_reg      <= stick_next;
            switch_reg     <= switch_next;
            idle_reg       <= idle_next;
            header_bad_reg <= header_bad_next;
            check_bad_reg  <= check_bad_next;
            arm_reg        <= arm_next;
        end
    end

endmodule

// File: rtl/rc_frame_check_failsafe_top.sv
// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid / s_tready  s_tdata: frame bytes, s_tuser: frame_present
// m_        out        m_tvalid / m_tready  m_tdata: arm, stop, sticks, presses, faults
// apb       in         psel / penable       four 8-bit registers at 0x0, 0x4, 0x8, 0xC
//
// One poll per cycle sustained while m_tready is high; a poll's result reaches m_ after its
// request passes the input register, then the result register. The poll logic is one pass
// of compares and masks on the registered state. aresetn is synchronous and active low;
// it resets config, state and valid registers but not data registers. When m_tready is low
// the result holds and the input register absorbs one more request before s_tready drops.
module rc_frame_check_failsafe_top (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] header_byte, [15:8] left_stick_x, [23:16] left_stick_y,
    // [31:24] right_stick_x, [39:32] right_stick_y, [47:40] switch_byte, [55:48] check_byte
    input  logic [55:0] s_tdata,
    // [0] frame_present
    input  logic [0:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] armed, [1] stop_motors, [9:2] thrust, [17:10] yaw, [25:18] pitch, [33:26] roll,
    // [34] left_press, [35] right_press, [36] header_fault, [37] checksum_fault,
    // [38] link_lost, [39] zero
    output logic [39:0] m_tdata,

    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [rcfc_pkg::CFG_ADDR_WIDTH-1:0]    paddr,
    input  logic [rcfc_pkg::CFG_DATA_WIDTH-1:0]    pwdata,
    output logic [rcfc_pkg::CFG_DATA_WIDTH-1:0]    prdata,
    output logic                                   pready
);

    rcfc_pkg::cfg_t      cfg_reg;
    rcfc_pkg::in_item_t  in_item_reg;
    logic                in_valid_reg;
    rcfc_pkg::out_item_t out_item_reg;
    logic                out_valid_reg;
    rcfc_pkg::out_item_t result;
    rcfc_pkg::in_item_t  s_item;
    logic                advance;
    logic                cfg_write;
    logic [1:0]          cfg_index;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_value     <= rcfc_pkg::HEADER_VALUE_RST;
            cfg_reg.disconnect_limit <= rcfc_pkg::DISCONNECT_LIMIT_RST;
            cfg_reg.arm_x_max        <= rcfc_pkg::ARM_X_MAX_RST;
            cfg_reg.arm_y_min        <= rcfc_pkg::ARM_Y_MIN_RST;
        end else if (cfg_write) begin
            case (cfg_index)
                rcfc_pkg::REG_HEADER_VALUE:     cfg_reg.header_value     <= pwdata[7:0];
                rcfc_pkg::REG_DISCONNECT_LIMIT: cfg_reg.disconnect_limit <= pwdata[7:0];
                rcfc_pkg::REG_ARM_X_MAX:        cfg_reg.arm_x_max        <= pwdata[7:0];
                rcfc_pkg::REG_ARM_Y_MIN:        cfg_reg.arm_y_min        <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            rcfc_pkg::REG_HEADER_VALUE:     prdata = {24'd0, cfg_reg.header_value};
            rcfc_pkg::REG_DISCONNECT_LIMIT: prdata = {24'd0, cfg_reg.disconnect_limit};
            rcfc_pkg::REG_ARM_X_MAX:        prdata = {24'd0, cfg_reg.arm_x_max};
            rcfc_pkg::REG_ARM_Y_MIN:        prdata = {24'd0, cfg_reg.arm_y_min};
            default:                        prdata = '0;
        endcase
    end

    // input register
    always_comb begin
        s_item.frame_present = s_tuser[0];
        s_item.header_byte   = s_tdata[7:0];
        s_item.left_stick_x  = s_tdata[15:8];
        s_item.left_stick_y  = s_tdata[23:16];
        s_item.right_stick_x = s_tdata[31:24];
        s_item.right_stick_y = s_tdata[39:32];
        s_item.switch_byte   = s_tdata[47:40];
        s_item.check_byte    = s_tdata[55:48];
    end

    // move the held request into the result register when that slot is free or draining
    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg <= s_item;
        end
    end

    rcfc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .cfg     (cfg_reg),
        .item    (in_item_reg),
        .result  (result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       out_item_reg.link_lost,
                       out_item_reg.checksum_fault,
                       out_item_reg.header_fault,
                       out_item_reg.right_press,
                       out_item_reg.left_press,
                       out_item_reg.roll,
                       out_item_reg.pitch,
                       out_item_reg.yaw,
                       out_item_reg.thrust,
                       out_item_reg.stop_motors,
                       out_item_reg.armed};

endmodule

// File: rtl/rcfc_checker.sv
`include "rc_frame_check_failsafe_top_defines.svh"

module rcfc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // a stalled result holds
    `RCFC_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // stop and armed never show together
    `RCFC_ASSERT(a_stop_disarms, m_tvalid |-> !(m_tdata[1] && m_tdata[0]), "armed while stop commanded")

    // a left press, a lost link or a fault forces a stop
    `RCFC_ASSERT(a_fault_stops, m_tvalid && (m_tdata[34] || m_tdata[36] || m_tdata[37] || m_tdata[38]) |-> m_tdata[1], "stop cause without stop")

    // reset drops the result channel
    `RCFC_ASSERT_RST(a_reset_idle, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind rc_frame_check_failsafe_top rcfc_checker u_rcfc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
